@@ hdl/qenf_pkg.sv @@
// ----------------------------------------------------------------------------
// qenf_pkg
// Shared widths and constants for the ENU/FLU <-> NED/FRD quaternion converter.
// ----------------------------------------------------------------------------
`default_nettype none

package qenf_pkg;

	// Component width of the quaternion ports
	localparam int QUAT_WIDTH = 32;
	// Magnitude of a combined component (sum or difference of two Q4.27 values, possibly negated)
	localparam int MAG_WIDTH  = 33;
	// Fraction bits of the output Q1.30 format
	localparam int OUT_FRAC   = 30;
	// Quotient bits produced by the divider
	localparam int QUOT_BITS  = 32;
	// Lane count
	localparam int LANES      = 4;

	typedef logic signed [QUAT_WIDTH-1:0] quat_comp_t;

	// Branch codes of the trace / largest-diagonal selection
	typedef enum logic [1:0] {
		BR_W = 2'd0,
		BR_X = 2'd1,
		BR_Y = 2'd2,
		BR_Z = 2'd3
	} branch_t;

endpackage

`default_nettype wire

@@ hdl/qenf_in_if.sv @@
// ----------------------------------------------------------------------------
// qenf_in_if
// Request channel carrying one input quaternion in Q4.27.
// ----------------------------------------------------------------------------
`default_nettype none

interface qenf_in_if import qenf_pkg::*; ();
	logic       valid;
	logic       ready;
	quat_comp_t in_w;
	quat_comp_t in_x;
	quat_comp_t in_y;
	quat_comp_t in_z;

	modport source (output valid, output in_w, output in_x, output in_y, output in_z,
		input ready);
	modport sink (input valid, input in_w, input in_x, input in_y, input in_z,
		output ready);
endinterface

`default_nettype wire

@@ hdl/qenf_out_if.sv @@
// ----------------------------------------------------------------------------
// qenf_out_if
// Result channel carrying the converted unit quaternion in Q1.30.
// ----------------------------------------------------------------------------
`default_nettype none

interface qenf_out_if import qenf_pkg::*; ();
	logic       valid;
	logic       ready;
	quat_comp_t out_w;
	quat_comp_t out_x;
	quat_comp_t out_y;
	quat_comp_t out_z;
	logic       norm_error;

	modport source (output valid, output out_w, output out_x, output out_y,
		output out_z, output norm_error, input ready);
	modport sink (input valid, input out_w, input out_x, input out_y,
		input out_z, input norm_error, output ready);
endinterface

`default_nettype wire

@@ hdl/quaternion_enu_flu_to_ned_frd_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_enu_flu_to_ned_frd_unit
// Re-expresses an attitude quaternion between the ENU/FLU and NED/FRD frames.
// ----------------------------------------------------------------------------
// The block takes one quaternion request per cycle while attitude.ready is
// high and returns one result per request, in order. The pipeline holds five
// front stages (combine, leading-one, normalize, square, sum and branch), one
// square-root stage per root bit (MANT_BITS + 1), one divider setup stage, one
// divider stage per quotient bit (32) and the output register. Every stage
// holds its request while the next one is full and stalled, so bubbles close
// up and an idle downstream never drops data. An input whose combined
// components are all zero sets norm_error and returns zero components.
`default_nettype none

module quaternion_enu_flu_to_ned_frd_unit
	import qenf_pkg::*;
#(
	parameter int COMP_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	qenf_in_if.sink     attitude,
	qenf_out_if.source  result
);

	localparam int MANT_BITS = (COMP_WIDTH - 1 > 31) ? 31 :
		((COMP_WIDTH - 1 < 8) ? 8 : COMP_WIDTH - 1);
	localparam int SUM_W    = 2 * MANT_BITS + 2;
	localparam int ROOT_W   = MANT_BITS + 1;
	localparam int DIVD_W   = MANT_BITS + OUT_FRAC + 1;
	localparam int DIVR_W   = ROOT_W + QUOT_BITS;
	localparam int SQ_STG   = MANT_BITS + 1;
	localparam int ST_SQ0   = 5;
	localparam int ST_DS    = ST_SQ0 + SQ_STG;
	localparam int ST_DV0   = ST_DS + 1;
	localparam int ST_OUT   = ST_DV0 + QUOT_BITS;
	localparam int NS       = ST_OUT + 1;

	typedef logic [MANT_BITS-1:0] mant_t;

	typedef struct packed {
		logic [LANES-1:0][MANT_BITS-1:0] m;
		logic [LANES-1:0]                neg;
		logic                            err;
		logic                            flip;
	} side_t;

	typedef struct packed {
		logic [LANES-1:0] neg;
		logic             err;
		logic             flip;
	} ctl_t;

	// Stage valids and per-stage load enables
	logic [NS-1:0] vld_q;
	logic [NS:0]   en;
	logic [NS-1:0] vprev;

	assign en[NS] = result.ready;
	assign vprev  = {vld_q[NS-2:0], attitude.valid};
	assign attitude.ready = en[0];

	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) vld_q[k] <= vprev[k];
			end
		end
	end

	// Stage 1: combined components, magnitudes and their OR
	logic signed [MAG_WIDTH:0] c_c [LANES];
	logic [MAG_WIDTH-1:0]      mag_c [LANES];
	logic [MAG_WIDTH-1:0]      orv_c;
	logic signed [MAG_WIDTH:0] w_e, x_e, y_e, z_e;

	always_comb begin
		w_e = {{2{attitude.in_w[QUAT_WIDTH-1]}}, attitude.in_w};
		x_e = {{2{attitude.in_x[QUAT_WIDTH-1]}}, attitude.in_x};
		y_e = {{2{attitude.in_y[QUAT_WIDTH-1]}}, attitude.in_y};
		z_e = {{2{attitude.in_z[QUAT_WIDTH-1]}}, attitude.in_z};
		c_c[BR_W] = -(w_e + z_e);
		c_c[BR_X] = -(x_e + y_e);
		c_c[BR_Y] = y_e - x_e;
		c_c[BR_Z] = z_e - w_e;
		orv_c = '0;
		for (int i = 0; i < LANES; i++) begin
			mag_c[i] = c_c[i][MAG_WIDTH] ? MAG_WIDTH'(-c_c[i]) : MAG_WIDTH'(c_c[i]);
			orv_c    = orv_c | mag_c[i];
		end
	end

	logic [MAG_WIDTH-1:0] mag_s1 [LANES];
	logic [LANES-1:0]     neg_s1;
	logic [MAG_WIDTH-1:0] orv_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < LANES; i++) begin
				mag_s1[i] <= mag_c[i];
				neg_s1[i] <= c_c[i][MAG_WIDTH];
			end
			orv_s1 <= orv_c;
		end
	end

	// Stage 2: leading-one of the largest magnitude gives the block shift
	logic [5:0] lead_c;
	logic [5:0] rsh_c, lsh_c;

	always_comb begin
		lead_c = '0;
		for (int i = 0; i < MAG_WIDTH; i++) begin
			if (orv_s1[i]) lead_c = 6'(i);
		end
		rsh_c = (lead_c >= 6'(MANT_BITS)) ? 6'(lead_c - 6'(MANT_BITS) + 6'd1) : '0;
		lsh_c = (lead_c <  6'(MANT_BITS)) ? 6'(6'(MANT_BITS - 1) - lead_c) : '0;
	end

	logic [MAG_WIDTH-1:0] mag_s2 [LANES];
	logic [LANES-1:0]     neg_s2;
	logic                 err_s2;
	logic [5:0]           rsh_s2, lsh_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			err_s2 <= (orv_s1 == '0);
			rsh_s2 <= rsh_c;
			lsh_s2 <= lsh_c;
		end
	end

	// Stage 3: normalize to MANT_BITS, right shifts truncate
	logic [MAG_WIDTH-1:0] shf_c [LANES];
	mant_t                m_s3 [LANES];
	logic [LANES-1:0]     neg_s3;
	logic                 err_s3;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			shf_c[i] = (mag_s2[i] >> rsh_s2) << lsh_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < LANES; i++) m_s3[i] <= shf_c[i][MANT_BITS-1:0];
			neg_s3 <= neg_s2;
			err_s3 <= err_s2;
		end
	end

	// Stage 4: squared mantissas
	logic [2*MANT_BITS-1:0] sq_s4 [LANES];
	mant_t                  m_s4 [LANES];
	logic [LANES-1:0]       neg_s4;
	logic                   err_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < LANES; i++) begin
				sq_s4[i] <= (2*MANT_BITS)'(m_s3[i]) * (2*MANT_BITS)'(m_s3[i]);
			end
			m_s4   <= m_s3;
			neg_s4 <= neg_s3;
			err_s4 <= err_s3;
		end
	end

	// Stage 5: squared norm and branch selection
	logic [SUM_W-1:0] sum_c, tr3_c, rest_c;
	branch_t          sel_c;
	logic             flip_c;
	side_t            side_c;

	always_comb begin
		sum_c  = SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]) + SUM_W'(sq_s4[3]);
		tr3_c  = SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[0]);
		rest_c = SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]) + SUM_W'(sq_s4[3]);
		if (tr3_c > rest_c)
			sel_c = BR_W;
		else if (sq_s4[1] > sq_s4[2] && sq_s4[1] > sq_s4[3])
			sel_c = BR_X;
		else if (sq_s4[2] > sq_s4[3])
			sel_c = BR_Y;
		else
			sel_c = BR_Z;
		flip_c = neg_s4[sel_c] && (m_s4[sel_c] != '0);
		for (int i = 0; i < LANES; i++) side_c.m[i] = m_s4[i];
		side_c.neg  = neg_s4;
		side_c.err  = err_s4;
		side_c.flip = flip_c;
	end

	// Square root: one root bit per stage, index 0 is the stage-5 register
	logic [SUM_W-1:0] sq_v_s   [SQ_STG+1];
	logic [SUM_W-1:0] sq_res_s [SQ_STG+1];
	side_t            sq_side_s [SQ_STG+1];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			sq_v_s[0]    <= sum_c;
			sq_res_s[0]  <= '0;
			sq_side_s[0] <= side_c;
		end
	end

	for (genvar j = 0; j < SQ_STG; j++) begin : g_sqrt
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQ_STG - 1 - j));
		logic [SUM_W-1:0] trial;
		assign trial = sq_res_s[j] + BIT;
		always_ff @(posedge clk) begin
			if (en[ST_SQ0 + j]) begin
				if (sq_v_s[j] >= trial) begin
					sq_v_s[j+1]   <= sq_v_s[j] - trial;
					sq_res_s[j+1] <= (sq_res_s[j] >> 1) + BIT;
				end else begin
					sq_v_s[j+1]   <= sq_v_s[j];
					sq_res_s[j+1] <= sq_res_s[j] >> 1;
				end
				sq_side_s[j+1] <= sq_side_s[j];
			end
		end
	end

	// Divider setup: rounding bias and scaled dividends
	logic [ROOT_W-1:0] nrm_c;
	logic [DIVD_W-1:0] dv_rem_s [QUOT_BITS+1][LANES];
	logic [QUOT_BITS-1:0] dv_q_s [QUOT_BITS+1][LANES];
	logic [ROOT_W-1:0] dv_nrm_s [QUOT_BITS+1];
	ctl_t              dv_ctl_s [QUOT_BITS+1];

	assign nrm_c = (sq_res_s[SQ_STG] == '0) ? ROOT_W'(1) : sq_res_s[SQ_STG][ROOT_W-1:0];

	always_ff @(posedge clk) begin
		if (en[ST_DS]) begin
			for (int i = 0; i < LANES; i++) begin
				dv_rem_s[0][i] <= (DIVD_W'(sq_side_s[SQ_STG].m[i]) << OUT_FRAC) +
					DIVD_W'(nrm_c >> 1);
				dv_q_s[0][i]   <= '0;
			end
			dv_nrm_s[0]      <= nrm_c;
			dv_ctl_s[0].neg  <= sq_side_s[SQ_STG].neg;
			dv_ctl_s[0].err  <= sq_side_s[SQ_STG].err;
			dv_ctl_s[0].flip <= sq_side_s[SQ_STG].flip;
		end
	end

	// Restoring divider: one quotient bit per stage, four lanes
	for (genvar d = 0; d < QUOT_BITS; d++) begin : g_div
		localparam int B = QUOT_BITS - 1 - d;
		logic [DIVR_W-1:0] dsh;
		assign dsh = DIVR_W'(dv_nrm_s[d]) << B;
		always_ff @(posedge clk) begin
			if (en[ST_DV0 + d]) begin
				for (int i = 0; i < LANES; i++) begin
					if (DIVR_W'(dv_rem_s[d][i]) >= dsh) begin
						dv_rem_s[d+1][i] <= DIVD_W'(DIVR_W'(dv_rem_s[d][i]) - dsh);
						dv_q_s[d+1][i]   <= dv_q_s[d][i] | (QUOT_BITS'(1) << B);
					end else begin
						dv_rem_s[d+1][i] <= dv_rem_s[d][i];
						dv_q_s[d+1][i]   <= dv_q_s[d][i];
					end
				end
				dv_nrm_s[d+1] <= dv_nrm_s[d];
				dv_ctl_s[d+1] <= dv_ctl_s[d];
			end
		end
	end

	// Output register: sign, saturation, zero on error
	logic [QUOT_BITS-1:0] fin_c [LANES];
	quat_comp_t           out_s [LANES];
	logic                 err_out_s;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (dv_ctl_s[QUOT_BITS].err) begin
				fin_c[i] = '0;
			end else if (dv_ctl_s[QUOT_BITS].neg[i] != dv_ctl_s[QUOT_BITS].flip) begin
				fin_c[i] = (dv_q_s[QUOT_BITS][i] > 32'h8000_0000) ? 32'h8000_0000 :
					32'(-dv_q_s[QUOT_BITS][i]);
			end else begin
				fin_c[i] = (dv_q_s[QUOT_BITS][i] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF :
					dv_q_s[QUOT_BITS][i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			for (int i = 0; i < LANES; i++) out_s[i] <= fin_c[i];
			err_out_s <= dv_ctl_s[QUOT_BITS].err;
		end
	end

	assign result.valid      = vld_q[NS-1];
	assign result.out_w      = out_s[BR_W];
	assign result.out_x      = out_s[BR_X];
	assign result.out_y      = out_s[BR_Y];
	assign result.out_z      = out_s[BR_Z];
	assign result.norm_error = err_out_s;

	// A flagged result carries zero components
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.norm_error |->
		result.out_w == '0 && result.out_x == '0 && result.out_y == '0 && result.out_z == '0)
		else $error("norm_error result with nonzero components");

	// A good result is a unit quaternion, so some component is nonzero
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.norm_error |->
		result.out_w != '0 || result.out_x != '0 || result.out_y != '0 || result.out_z != '0)
		else $error("good result with all components zero");

	// Root is never below any mantissa, so quotients stay within 1.0
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_OUT-1] && !dv_ctl_s[QUOT_BITS].err |->
		dv_q_s[QUOT_BITS][0] <= 32'h4000_0000 && dv_q_s[QUOT_BITS][1] <= 32'h4000_0000 &&
		dv_q_s[QUOT_BITS][2] <= 32'h4000_0000 && dv_q_s[QUOT_BITS][3] <= 32'h4000_0000)
		else $error("quotient above 1.0");

endmodule

`default_nettype wire

@@ tb/sv/qenf_tb_if.sv @@
// ----------------------------------------------------------------------------
// qenf_tb_if
// Testbench side of the channels: nothing extra, the RTL interfaces are used.
// ----------------------------------------------------------------------------
// The block's own interface files carry valid, ready and the payload with
// source and sink modports; the testbench instantiates them directly.
`default_nettype none

package qenf_tb_pkg;
	import qenf_pkg::*;

	typedef struct packed {
		quat_comp_t w;
		quat_comp_t x;
		quat_comp_t y;
		quat_comp_t z;
	} attitude_t;

	typedef struct packed {
		quat_comp_t w;
		quat_comp_t x;
		quat_comp_t y;
		quat_comp_t z;
		logic       norm_error;
	} converted_t;
endpackage

`default_nettype wire

@@ tb/sv/quaternion_enu_flu_to_ned_frd_unit_tb.sv @@
// ----------------------------------------------------------------------------
// quaternion_enu_flu_to_ned_frd_unit_tb
// Self-checking bench for the ENU/FLU <-> NED/FRD quaternion converter.
// ----------------------------------------------------------------------------
// Directed corner quaternions, then random ones of varied magnitude, are sent
// with random gaps; results are taken with random stalls and compared field by
// field against a bit-exact fixed-point predictor, in order.
`default_nettype none

module quaternion_enu_flu_to_ned_frd_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qenf_pkg::*;
	import qenf_tb_pkg::*;

	localparam int COMP_W    = 32;
	localparam int MANT      = (COMP_W - 1 > 31) ? 31 : ((COMP_W - 1 < 8) ? 8 : COMP_W - 1);
	localparam int CYC_LIMIT = 400000;
	localparam int DRAIN     = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycle = 0;
	int   errors = 0;
	bit   stim_done = 1'b0;

	converted_t expected_q[$];

	qenf_in_if  attitude();
	qenf_out_if result();

	quaternion_enu_flu_to_ned_frd_unit #(.COMP_WIDTH(COMP_W)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.attitude(attitude.sink),
		.result (result.source)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Cycle watchdog
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYC_LIMIT) begin
			$display("quaternion_enu_flu_to_ned_frd_unit_tb failed");
			$finish;
		end
	end

	// Integer square root, floor
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Frame conversion predictor
	function automatic converted_t convert_frame(input attitude_t a);
		converted_t  r;
		logic signed [63:0] c [4];
		logic [63:0] mag [4];
		logic [63:0] sq [4];
		logic        neg [4];
		logic [63:0] maxm, lim, sum, norm, q;
		logic [31:0] v [4];
		branch_t     sel;
		logic        flip, s;
		int          k;
		c[0] = -(64'(a.w) + 64'(a.z));
		c[1] = -(64'(a.x) + 64'(a.y));
		c[2] = 64'(a.y) - 64'(a.x);
		c[3] = 64'(a.z) - 64'(a.w);
		maxm = 0;
		for (int i = 0; i < 4; i++) begin
			neg[i] = c[i] < 0;
			mag[i] = neg[i] ? 64'(-c[i]) : 64'(c[i]);
			if (mag[i] > maxm) maxm = mag[i];
		end
		r = '0;
		if (maxm == 0) begin
			r.norm_error = 1'b1;
			return r;
		end
		lim = 64'd1 << MANT;
		if (maxm >= lim) begin
			k = 0;
			while ((maxm >> k) >= lim) k++;
			for (int i = 0; i < 4; i++) mag[i] = mag[i] >> k;
		end else begin
			k = 0;
			while ((maxm << k) < (lim >> 1)) k++;
			for (int i = 0; i < 4; i++) mag[i] = mag[i] << k;
		end
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			sq[i] = mag[i] * mag[i];
			sum   = sum + sq[i];
		end
		if (3 * sq[0] > sq[1] + sq[2] + sq[3]) sel = BR_W;
		else if (sq[1] > sq[2] && sq[1] > sq[3]) sel = BR_X;
		else if (sq[2] > sq[3]) sel = BR_Y;
		else sel = BR_Z;
		flip = neg[sel] && mag[sel] != 0;
		norm = isqrt64(sum);
		if (norm == 0) norm = 1;
		for (int i = 0; i < 4; i++) begin
			q = ((mag[i] << OUT_FRAC) + norm / 2) / norm;
			s = neg[i] != flip;
			if (s) begin
				if (q > 64'h8000_0000) q = 64'h8000_0000;
				v[i] = 32'(64'd0 - q);
			end else begin
				if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
				v[i] = 32'(q);
			end
		end
		r.w = v[0];
		r.x = v[1];
		r.y = v[2];
		r.z = v[3];
		r.norm_error = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s at cycle %0d: got %h want %h", what, cycle, got, want);
		errors++;
	endtask

	// Request driver
	initial begin
		attitude.valid = 1'b0;
		attitude.in_w  = '0;
		attitude.in_x  = '0;
		attitude.in_y  = '0;
		attitude.in_z  = '0;
	end

	task automatic send_attitude(input attitude_t a);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) begin
			attitude.valid <= 1'b0;
			@(posedge clk);
		end
		attitude.valid <= 1'b1;
		attitude.in_w  <= a.w;
		attitude.in_x  <= a.x;
		attitude.in_y  <= a.y;
		attitude.in_z  <= a.z;
		expected_q.push_back(convert_frame(a));
		do @(posedge clk); while (!attitude.ready);
	endtask

	// Result side: random stall, compare on each accepted result
	initial begin
		converted_t want;
		int stall;
		result.ready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					$display("unexpected result at cycle %0d", cycle);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (result.out_w !== want.w) report_mismatch("out_w", result.out_w, want.w);
					if (result.out_x !== want.x) report_mismatch("out_x", result.out_x, want.x);
					if (result.out_y !== want.y) report_mismatch("out_y", result.out_y, want.y);
					if (result.out_z !== want.z) report_mismatch("out_z", result.out_z, want.z);
					if (result.norm_error !== want.norm_error)
						report_mismatch("norm_error", 32'(result.norm_error),
							32'(want.norm_error));
				end
			end
			if (stall > 0) begin
				stall--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
				if (result.valid && result.ready && $urandom_range(0, 2) == 0)
					stall = $urandom_range(0, 10);
			end
		end
	end

	function automatic quat_comp_t rand_comp();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 255)) - 128;
			2: return $signed($urandom) >>> $urandom_range(0, 31);
			3: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
			4: return 32'sh8000_0000 + $urandom_range(0, 3);
			default: return $signed($urandom) >>> 4;
		endcase
	endfunction

	task automatic test_directed();
		attitude_t a;
		quat_comp_t ext [6];
		ext = '{32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0800_0000, -32'sh0800_0000, 32'sh1};
		send_attitude('{w: 0, x: 0, y: 0, z: 0});
		send_attitude('{w: 32'sh0800_0000, x: 0, y: 0, z: 0});
		send_attitude('{w: 0, x: 32'sh0800_0000, y: 0, z: 0});
		send_attitude('{w: 0, x: 0, y: 32'sh0800_0000, z: 0});
		send_attitude('{w: 0, x: 0, y: 0, z: 32'sh0800_0000});
		// opposite pairs cancel to a zero combined part
		send_attitude('{w: 5, x: 7, y: -7, z: -5});
		send_attitude('{w: 1, x: 1, y: 1, z: 1});
		send_attitude('{w: 32'sh7FFF_FFFF, x: 32'sh7FFF_FFFF, y: 32'sh7FFF_FFFF,
			z: 32'sh7FFF_FFFF});
		send_attitude('{w: 32'sh8000_0000, x: 32'sh8000_0000, y: 32'sh8000_0000,
			z: 32'sh8000_0000});
		send_attitude('{w: -1, x: -1, y: -1, z: -1});
		for (int i = 0; i < 14; i++) begin
			a.w = ext[$urandom_range(0, 5)];
			a.x = ext[$urandom_range(0, 5)];
			a.y = ext[$urandom_range(0, 5)];
			a.z = ext[$urandom_range(0, 5)];
			send_attitude(a);
		end
	endtask

	task automatic test_random(input int n);
		attitude_t a;
		for (int i = 0; i < n; i++) begin
			a.w = rand_comp();
			a.x = rand_comp();
			a.y = rand_comp();
			a.z = rand_comp();
			send_attitude(a);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1750);
		attitude.valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("quaternion_enu_flu_to_ned_frd_unit_tb passed");
		end else begin
			$display("quaternion_enu_flu_to_ned_frd_unit_tb failed");
		end
		$finish;
	end
endmodule

`default_nettype wire

@@ sim.f @@
hdl/qenf_pkg.sv
hdl/qenf_in_if.sv
hdl/qenf_out_if.sv
hdl/quaternion_enu_flu_to_ned_frd_unit.sv
tb/sv/qenf_tb_if.sv
tb/sv/quaternion_enu_flu_to_ned_frd_unit_tb.sv
